[rtl/core/h2sps_pkg.sv]
// Shared types, codes and CRC helper for the hydrogen sensor poll sequencer.
// No dependencies; used by every file in rtl/core but h2sps_if.
package h2sps_pkg;

    typedef logic [15:0] t_crc;
    typedef logic [7:0]  t_byte;

    // Bus action codes.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Reply status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUS    = 2'd1;
    localparam logic [1:0] ST_CRC    = 2'd2;
    localparam logic [1:0] ST_SENSOR = 2'd3;

    // Frame lengths in bytes.
    localparam logic [2:0] LEN_NONE      = 3'd0;
    localparam logic [2:0] LEN_CONC_CMD  = 3'd7;
    localparam logic [2:0] LEN_TEMP_CMD  = 3'd3;
    localparam logic [2:0] LEN_CONC_RPLY = 3'd5;
    localparam logic [2:0] LEN_TEMP_RPLY = 3'd4;

    // Command bytes and CRC-16/CCITT-FALSE parameters.
    localparam t_byte C_CMD_CONC  = 8'hA8;
    localparam t_byte C_CMD_CONC2 = 8'h60;
    localparam t_byte C_CMD_TEMP  = 8'hA9;
    localparam t_crc  C_CRC_POLY  = 16'h1021;
    localparam t_crc  C_CRC_INIT  = 16'hFFFF;

    // Clamp limits.
    localparam logic [7:0] C_HUM_MAX  = 8'd255;
    localparam logic [9:0] C_TNEG_MAX = 10'd40;
    localparam logic [9:0] C_TPOS_MAX = 10'd105;
    localparam logic [7:0] C_PRES_MIN = 8'd50;
    localparam logic [7:0] C_PRES_MAX = 8'd130;

    // Register indexes and reset values.
    localparam logic       REG_PERIOD      = 1'b0;
    localparam logic       REG_TIMEOUT     = 1'b1;
    localparam logic [15:0] C_PERIOD_RST   = 16'd60;
    localparam logic [15:0] C_TIMEOUT_RST  = 16'd550;

    // One byte through the CRC, MSB first.
    function automatic t_crc crc_byte(input t_crc crc_in, input t_byte data);
        t_crc c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ C_CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // CRC after the fixed two-byte concentration prefix.
    localparam t_crc C_CRC_CONC_PFX = crc_byte(crc_byte(C_CRC_INIT, C_CMD_CONC), C_CMD_CONC2);
    localparam t_crc C_CRC_TEMP_CMD = crc_byte(C_CRC_INIT, C_CMD_TEMP);

    // Reply checker results for both reply kinds.
    typedef struct packed {
        logic [1:0]  conc_status;
        logic [1:0]  temp_status;
        logic [15:0] h2_word;
        t_byte       temp_byte;
    } t_rx_chk;

endpackage

[rtl/core/h2sps_if.sv]
// Channel interfaces: tick input and result output of the poll sequencer.
// Depends on nothing beyond the port widths of h2sps_pkg users.
interface h2sps_tick_if;
    logic               valid;
    logic               ready;
    logic        [10:0] humidity_q4;
    logic signed [12:0] ambient_temp_q4;
    logic        [11:0] pressure_mbar;
    logic        [39:0] rx_frame;
    logic               rx_ack;

    modport source (output valid, humidity_q4, ambient_temp_q4, pressure_mbar, rx_frame,
                    rx_ack, input ready);
    modport sink   (input valid, humidity_q4, ambient_temp_q4, pressure_mbar, rx_frame,
                    rx_ack, output ready);
endinterface

interface h2sps_res_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  bus_action;
    logic        [55:0] tx_frame;
    logic        [2:0]  tx_length;
    logic        [2:0]  rx_length;
    logic        [1:0]  read_status;
    logic signed [15:0] h2_value;
    logic               h2_valid;
    logic signed [7:0]  temperature_c;
    logic               temp_valid;
    logic               error_flag;

    modport source (output valid, bus_action, tx_frame, tx_length, rx_length, read_status,
                    h2_value, h2_valid, temperature_c, temp_valid, error_flag, input ready);
    modport sink   (input valid, bus_action, tx_frame, tx_length, rx_length, read_status,
                    h2_value, h2_valid, temperature_c, temp_valid, error_flag, output ready);
endinterface

[rtl/core/h2sps_cmd.sv]
// Concentration command builder: rounds and clamps compensation values, appends CRC.
// Depends on h2sps_pkg.
module h2sps_cmd (
    input  logic        [10:0] i_humidity_q4,
    input  logic signed [12:0] i_ambient_temp_q4,
    input  logic        [11:0] i_pressure_mbar,
    output logic        [55:0] o_frame
);
    localparam logic [12:0] C_RECIP10 = 13'd6554; // 2^16 / 10, rounded up
    localparam logic [12:0] C_PSUM_LO = 13'd500;  // below: clamp to minimum
    localparam logic [12:0] C_PSUM_HI = 13'd1310; // at or above: clamp to maximum

    logic [11:0] hum_sum;
    logic [9:0]  hum_q;
    logic [7:0]  hum_b;
    logic        t_neg;
    logic [12:0] t_mag;
    logic [13:0] t_sum;
    logic [9:0]  t_rnd;
    logic [9:0]  t_lim;
    logic [7:0]  temp_b;
    logic [12:0] p_sum;
    logic [25:0] p_prod;
    logic [7:0]  pres_b;
    logic [15:0] crc;

    always_comb begin
        // Humidity: round to whole percent, saturate at one byte.
        hum_sum = {1'b0, i_humidity_q4} + 12'd2;
        hum_q   = hum_sum[11:2];
        hum_b   = (hum_q > {2'b00, h2sps_pkg::C_HUM_MAX}) ? h2sps_pkg::C_HUM_MAX : hum_q[7:0];

        // Temperature: round half away from zero on the magnitude.
        t_neg  = i_ambient_temp_q4[12];
        t_mag  = t_neg ? (13'd0 - i_ambient_temp_q4) : i_ambient_temp_q4;
        t_sum  = {1'b0, t_mag} + 14'd8;
        t_rnd  = t_sum[13:4];
        if (t_neg) begin
            t_lim = (t_rnd > h2sps_pkg::C_TNEG_MAX) ? h2sps_pkg::C_TNEG_MAX : t_rnd;
        end else begin
            t_lim = (t_rnd > h2sps_pkg::C_TPOS_MAX) ? h2sps_pkg::C_TPOS_MAX : t_rnd;
        end
        temp_b = t_neg ? (8'd0 - t_lim[7:0]) : t_lim[7:0];

        // Pressure: mbar to kPa half up, divide by ten through a reciprocal.
        p_sum  = {1'b0, i_pressure_mbar} + 13'd5;
        p_prod = p_sum * C_RECIP10;
        if (p_sum < C_PSUM_LO) begin
            pres_b = h2sps_pkg::C_PRES_MIN;
        end else if (p_sum >= C_PSUM_HI) begin
            pres_b = h2sps_pkg::C_PRES_MAX;
        end else begin
            pres_b = p_prod[23:16];
        end

        crc = h2sps_pkg::crc_byte(h2sps_pkg::crc_byte(h2sps_pkg::crc_byte(
                  h2sps_pkg::C_CRC_CONC_PFX, hum_b), temp_b), pres_b);
        o_frame = {h2sps_pkg::C_CMD_CONC, h2sps_pkg::C_CMD_CONC2, hum_b, temp_b, pres_b, crc};
    end

endmodule

[rtl/core/h2sps_rx_chk.sv]
// Reply checker: acknowledge, CRC and status byte for both reply kinds.
// Depends on h2sps_pkg.
module h2sps_rx_chk (
    input  logic [39:0]         i_rx_frame,
    input  logic                i_rx_ack,
    output h2sps_pkg::t_rx_chk  o_chk
);
    h2sps_pkg::t_byte b0, b1, b2, b3, b4;
    h2sps_pkg::t_crc  c1, c2, c3;

    always_comb begin
        b0 = i_rx_frame[39:32];
        b1 = i_rx_frame[31:24];
        b2 = i_rx_frame[23:16];
        b3 = i_rx_frame[15:8];
        b4 = i_rx_frame[7:0];
        c1 = h2sps_pkg::crc_byte(h2sps_pkg::C_CRC_INIT, b0);
        c2 = h2sps_pkg::crc_byte(c1, b1);
        c3 = h2sps_pkg::crc_byte(c2, b2);

        // Five-byte concentration reply: CRC in bytes three and four.
        priority if (!i_rx_ack) begin
            o_chk.conc_status = h2sps_pkg::ST_BUS;
        end else if (c3 != {b3, b4}) begin
            o_chk.conc_status = h2sps_pkg::ST_CRC;
        end else if (b0 != 8'd0) begin
            o_chk.conc_status = h2sps_pkg::ST_SENSOR;
        end else begin
            o_chk.conc_status = h2sps_pkg::ST_OK;
        end

        // Four-byte temperature reply: CRC in bytes two and three.
        priority if (!i_rx_ack) begin
            o_chk.temp_status = h2sps_pkg::ST_BUS;
        end else if (c2 != {b2, b3}) begin
            o_chk.temp_status = h2sps_pkg::ST_CRC;
        end else if (b0 != 8'd0) begin
            o_chk.temp_status = h2sps_pkg::ST_SENSOR;
        end else begin
            o_chk.temp_status = h2sps_pkg::ST_OK;
        end

        o_chk.h2_word   = {b1, b2};
        o_chk.temp_byte = b1;
    end

endmodule

[rtl/core/h2_sensor_poll_sequencer_unit.sv]
// Top level of the hydrogen sensor poll sequencer: phase state, timers, APB registers.
// Depends on h2sps_pkg, h2sps_if, h2sps_cmd and h2sps_rx_chk.
//
//  channel   | dir | handshake     | beat contents
//  ----------+-----+---------------+------------------------------------------------
//  i_tick    | in  | valid / ready | one 1 ms tick: compensation values, reply bytes
//  o_res     | out | valid / ready | bus action, frames, lengths, status, readings
//  APB       | in  | psel/penable  | phase period (0x0), timeout (0x4), 32-bit data
//
// Each tick beat passes through two registers: an input register, then the
// result register; one beat is taken every cycle while o_res is not stalled.
// The phase timer, age counter and stores update when a beat leaves the input
// register, so the tick-to-tick dependency closes before the next beat leaves it.
// Reset (i_rst_n low, synchronous) empties both registers and restores state.
// A stalled result holds the result register; the input register then holds
// its beat and i_tick.ready drops only when both are full.
module h2_sensor_poll_sequencer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    h2sps_tick_if.sink         i_tick,
    h2sps_res_if.source        o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    // One-hot phase: send concentration command, read it, send temperature
    // command, read it.
    typedef enum logic [3:0] {
        P_CONC_CMD = 4'b0001,
        P_CONC_RD  = 4'b0010,
        P_TEMP_CMD = 4'b0100,
        P_TEMP_RD  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]  bus_action;
        logic [55:0] tx_frame;
        logic [2:0]  tx_length;
        logic [2:0]  rx_length;
        logic [1:0]  read_status;
        logic [15:0] h2_value;
        logic        h2_valid;
        logic [7:0]  temperature_c;
        logic        temp_valid;
        logic        error_flag;
    } t_result;

    localparam logic [55:0] C_TEMP_FRAME =
        {h2sps_pkg::C_CMD_TEMP, h2sps_pkg::C_CRC_TEMP_CMD, 32'd0};

    // Configuration registers.
    logic [15:0] r_period, r_timeout;
    logic        cfg_wr;

    // Input register.
    logic        r_s1_vld;
    logic [10:0] r_s1_hum;
    logic [12:0] r_s1_temp;
    logic [11:0] r_s1_pres;
    logic [39:0] r_s1_rx;
    logic        r_s1_ack;

    // Sequencer state.
    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [15:0] r_age, n_age;
    logic [15:0] r_h2, n_h2;
    logic        r_h2_ok, n_h2_ok;
    logic [7:0]  r_temp, n_temp;
    logic        r_temp_ok, n_temp_ok;
    logic        r_fault, n_fault;

    // Result register.
    logic        r_out_vld;
    t_result     r_out, n_out;

    logic        s1_adv;
    logic        act;
    logic [15:0] timer_inc, age_inc;
    logic [55:0] conc_frame;
    h2sps_pkg::t_rx_chk chk;

    // APB: no wait states, read back both registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == h2sps_pkg::REG_TIMEOUT) ? {16'd0, r_timeout}
                                                         : {16'd0, r_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= h2sps_pkg::C_PERIOD_RST;
            r_timeout <= h2sps_pkg::C_TIMEOUT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == h2sps_pkg::REG_PERIOD) begin
                r_period <= pwdata[15:0];
            end else begin
                r_timeout <= pwdata[15:0];
            end
        end
    end

    // Advance a beat out of the input register whenever the result register frees up.
    assign s1_adv       = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_tick.ready = !r_s1_vld || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_tick.valid || (r_s1_vld && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_s1_hum  <= i_tick.humidity_q4;
            r_s1_temp <= i_tick.ambient_temp_q4;
            r_s1_pres <= i_tick.pressure_mbar;
            r_s1_rx   <= i_tick.rx_frame;
            r_s1_ack  <= i_tick.rx_ack;
        end
    end

    h2sps_cmd u_cmd (
        .i_humidity_q4     (r_s1_hum),
        .i_ambient_temp_q4 (r_s1_temp),
        .i_pressure_mbar   (r_s1_pres),
        .o_frame           (conc_frame)
    );

    h2sps_rx_chk u_rx_chk (
        .i_rx_frame (r_s1_rx),
        .i_rx_ack   (r_s1_ack),
        .o_chk      (chk)
    );

    // One tick of the sequencer.
    always_comb begin
        timer_inc = (r_timer == 16'hFFFF) ? r_timer : r_timer + 16'd1;
        age_inc   = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;
        act       = (timer_inc >= r_period);

        n_phase   = r_phase;
        n_timer   = timer_inc;
        n_age     = age_inc;
        n_h2      = r_h2;
        n_h2_ok   = r_h2_ok;
        n_temp    = r_temp;
        n_temp_ok = r_temp_ok;
        n_fault   = r_fault;

        n_out.bus_action  = h2sps_pkg::ACT_NONE;
        n_out.tx_frame    = 56'd0;
        n_out.tx_length   = h2sps_pkg::LEN_NONE;
        n_out.rx_length   = h2sps_pkg::LEN_NONE;
        n_out.read_status = h2sps_pkg::ST_OK;

        if (act) begin
            n_timer = 16'd0;
            unique case (r_phase)
                P_CONC_CMD: begin
                    n_out.bus_action = h2sps_pkg::ACT_WRITE;
                    n_out.tx_frame   = conc_frame;
                    n_out.tx_length  = h2sps_pkg::LEN_CONC_CMD;
                    n_phase          = P_CONC_RD;
                end
                P_CONC_RD: begin
                    n_out.bus_action  = h2sps_pkg::ACT_READ;
                    n_out.rx_length   = h2sps_pkg::LEN_CONC_RPLY;
                    n_out.read_status = chk.conc_status;
                    if (chk.conc_status == h2sps_pkg::ST_OK) begin
                        n_h2    = chk.h2_word;
                        n_h2_ok = 1'b1;
                        n_fault = 1'b0;
                        n_age   = 16'd0;
                    end
                    n_phase = P_TEMP_CMD;
                end
                P_TEMP_CMD: begin
                    n_out.bus_action = h2sps_pkg::ACT_WRITE;
                    n_out.tx_frame   = C_TEMP_FRAME;
                    n_out.tx_length  = h2sps_pkg::LEN_TEMP_CMD;
                    n_phase          = P_TEMP_RD;
                end
                P_TEMP_RD: begin
                    n_out.bus_action  = h2sps_pkg::ACT_READ;
                    n_out.rx_length   = h2sps_pkg::LEN_TEMP_RPLY;
                    n_out.read_status = chk.temp_status;
                    if (chk.temp_status == h2sps_pkg::ST_OK) begin
                        n_temp    = chk.temp_byte;
                        n_temp_ok = 1'b1;
                    end
                    n_phase = P_CONC_CMD;
                end
                default: begin
                    n_phase = P_CONC_CMD;
                end
            endcase
        end

        // Drop stale readings once the age passes the timeout.
        if (n_age > r_timeout) begin
            n_h2      = 16'd0;
            n_h2_ok   = 1'b0;
            n_temp    = 8'd0;
            n_temp_ok = 1'b0;
            n_fault   = 1'b1;
        end

        n_out.h2_value      = n_h2;
        n_out.h2_valid      = n_h2_ok;
        n_out.temperature_c = n_temp;
        n_out.temp_valid    = n_temp_ok;
        n_out.error_flag    = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= P_CONC_CMD;
            r_timer   <= 16'd0;
            r_age     <= 16'd0;
            r_h2      <= 16'd0;
            r_h2_ok   <= 1'b0;
            r_temp    <= 8'd0;
            r_temp_ok <= 1'b0;
            r_fault   <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_phase   <= n_phase;
                r_timer   <= n_timer;
                r_age     <= n_age;
                r_h2      <= n_h2;
                r_h2_ok   <= n_h2_ok;
                r_temp    <= n_temp;
                r_temp_ok <= n_temp_ok;
                r_fault   <= n_fault;
            end
            r_out_vld <= s1_adv || (r_out_vld && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.bus_action    = r_out.bus_action;
    assign o_res.tx_frame      = r_out.tx_frame;
    assign o_res.tx_length     = r_out.tx_length;
    assign o_res.rx_length     = r_out.rx_length;
    assign o_res.read_status   = r_out.read_status;
    assign o_res.h2_value      = r_out.h2_value;
    assign o_res.h2_valid      = r_out.h2_valid;
    assign o_res.temperature_c = r_out.temperature_c;
    assign o_res.temp_valid    = r_out.temp_valid;
    assign o_res.error_flag    = r_out.error_flag;

    // A valid concentration reading and the error flag never coexist.
    a_ok_vs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h2_ok != r_fault)
        else $error("h2 valid and error flag out of step");

    // The phase moves only on a tick whose timer reached the period.
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_adv && act) |=> $stable(r_phase))
        else $error("phase changed without a phase action");

    a_phase_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && act) |=> (r_phase != $past(r_phase)))
        else $error("phase did not advance on a phase action");

    // Both stages full and the output stalled: the input side must stall too.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !o_res.ready) |-> !i_tick.ready)
        else $error("tick accepted with no room");

    // A write result carries a frame length, a read result a reply length.
    a_len_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (((r_out.bus_action == h2sps_pkg::ACT_WRITE) == (r_out.tx_length != 3'd0))
                    && ((r_out.bus_action == h2sps_pkg::ACT_READ) == (r_out.rx_length != 3'd0))))
        else $error("bus action and lengths disagree");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the hydrogen sensor poll sequencer: random and directed ticks,
// a predictor of its own and a scoreboard. Depends on h2sps_pkg, the h2sps_tick_if and
// h2sps_res_if channels, and h2_sensor_poll_sequencer_unit.
`timescale 1ns / 100ps

module testbench;

    // Poll phases, in the order the sequencer walks them.
    typedef enum logic [1:0] {
        PH_CONC_CMD  = 2'd0,
        PH_CONC_READ = 2'd1,
        PH_TEMP_CMD  = 2'd2,
        PH_TEMP_READ = 2'd3
    } t_seq_phase;

    // Shapes of sensor reply placed on a tick.
    typedef enum int {
        RPLY_GOOD   = 0,
        RPLY_NOACK  = 1,
        RPLY_BADCRC = 2,
        RPLY_STATUS = 3,
        RPLY_NOISE  = 4
    } t_reply_kind;

    typedef struct packed {
        logic        [10:0] humidity_q4;
        logic signed [12:0] ambient_temp_q4;
        logic        [11:0] pressure_mbar;
        logic        [39:0] rx_frame;
        logic               rx_ack;
    } t_tick_beat;

    typedef struct packed {
        logic        [1:0]  bus_action;
        logic        [55:0] tx_frame;
        logic        [2:0]  tx_length;
        logic        [2:0]  rx_length;
        logic        [1:0]  read_status;
        logic signed [15:0] h2_value;
        logic               h2_valid;
        logic signed [7:0]  temperature_c;
        logic               temp_valid;
        logic               error_flag;
    } t_poll_beat;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    h2sps_tick_if tick_ch ();
    h2sps_res_if  res_ch ();

    h2_sensor_poll_sequencer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted sequencer state and its own copy of the registers.
    t_seq_phase  seq_phase;
    logic [15:0] seq_timer;
    logic [15:0] age_ms;
    logic [15:0] h2_word;
    logic        h2_have;
    logic [7:0]  temp_byte;
    logic        temp_have;
    logic        err_bit;
    logic [15:0] cfg_period;
    logic [15:0] cfg_timeout;

    // Result beats still owed by the block, oldest first.
    t_poll_beat  due_beats[$];

    int fail_count;
    int send_idle_pct;
    int stall_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= 50) begin
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
        end
    endtask

    // CRC-16/CCITT-FALSE, one bit at a time, over the first n bytes.
    function automatic logic [15:0] crc16_of(input logic [7:0] bytes [7], input int n);
        logic [15:0] c;
        logic        fb;
        int          i, k;
        c = h2sps_pkg::C_CRC_INIT;
        for (i = 0; i < n; i++) begin
            for (k = 7; k >= 0; k--) begin
                fb = c[15] ^ bytes[i][k];
                c  = {c[14:0], 1'b0};
                if (fb) c = c ^ h2sps_pkg::C_CRC_POLY;
            end
        end
        return c;
    endfunction

    // Judge a reply of n bytes: bus acknowledge first, then CRC, then status byte.
    function automatic logic [1:0] reply_status(input logic [39:0] rx, input logic ack,
                                                input int n);
        logic [7:0] rb [7];
        int         i;
        for (i = 0; i < 7; i++) rb[i] = (i < 5) ? rx[39 - 8 * i -: 8] : 8'h00;
        if (!ack) return h2sps_pkg::ST_BUS;
        if (crc16_of(rb, n - 2) != {rb[n - 2], rb[n - 1]}) return h2sps_pkg::ST_CRC;
        if (rb[0] != 8'h00) return h2sps_pkg::ST_SENSOR;
        return h2sps_pkg::ST_OK;
    endfunction

    task automatic reset_model();
        seq_phase   = PH_CONC_CMD;
        seq_timer   = '0;
        age_ms      = '0;
        h2_word     = '0;
        h2_have     = 1'b0;
        temp_byte   = '0;
        temp_have   = 1'b0;
        err_bit     = 1'b1;
        cfg_period  = h2sps_pkg::C_PERIOD_RST;
        cfg_timeout = h2sps_pkg::C_TIMEOUT_RST;
    endtask

    // Advance the predicted sequencer by one tick and queue the result it owes.
    task automatic advance_sequencer(input t_tick_beat t);
        t_poll_beat  e;
        logic [7:0]  fb [7];
        logic [15:0] crc;
        int          hum_b, deg, pres_b, traw, i;
        e = '0;
        for (i = 0; i < 7; i++) fb[i] = 8'h00;
        if (seq_timer != 16'hFFFF) seq_timer++;
        if (age_ms != 16'hFFFF) age_ms++;
        if (seq_timer >= cfg_period) begin
            seq_timer = '0;
            case (seq_phase)
                PH_CONC_CMD: begin
                    // Round each compensation value to one byte, then clamp.
                    hum_b = (int'(t.humidity_q4) + 2) >> 2;
                    if (hum_b > int'(h2sps_pkg::C_HUM_MAX)) hum_b = int'(h2sps_pkg::C_HUM_MAX);
                    traw = $signed(t.ambient_temp_q4);
                    deg  = (traw < 0) ? -((8 - traw) / 16) : (traw + 8) / 16;
                    if (deg < -int'(h2sps_pkg::C_TNEG_MAX)) deg = -int'(h2sps_pkg::C_TNEG_MAX);
                    if (deg > int'(h2sps_pkg::C_TPOS_MAX)) deg = int'(h2sps_pkg::C_TPOS_MAX);
                    pres_b = (int'(t.pressure_mbar) + 5) / 10;
                    if (pres_b < int'(h2sps_pkg::C_PRES_MIN))
                        pres_b = int'(h2sps_pkg::C_PRES_MIN);
                    if (pres_b > int'(h2sps_pkg::C_PRES_MAX))
                        pres_b = int'(h2sps_pkg::C_PRES_MAX);
                    fb[0] = h2sps_pkg::C_CMD_CONC;
                    fb[1] = h2sps_pkg::C_CMD_CONC2;
                    fb[2] = hum_b[7:0];
                    fb[3] = deg[7:0];
                    fb[4] = pres_b[7:0];
                    crc = crc16_of(fb, 5);
                    e.bus_action = h2sps_pkg::ACT_WRITE;
                    e.tx_frame   = {fb[0], fb[1], fb[2], fb[3], fb[4], crc};
                    e.tx_length  = h2sps_pkg::LEN_CONC_CMD;
                end
                PH_CONC_READ: begin
                    e.bus_action  = h2sps_pkg::ACT_READ;
                    e.rx_length   = h2sps_pkg::LEN_CONC_RPLY;
                    e.read_status = reply_status(t.rx_frame, t.rx_ack, 5);
                    if (e.read_status == h2sps_pkg::ST_OK) begin
                        h2_word = t.rx_frame[31:16];
                        h2_have = 1'b1;
                        err_bit = 1'b0;
                        age_ms  = '0;
                    end
                end
                PH_TEMP_CMD: begin
                    fb[0] = h2sps_pkg::C_CMD_TEMP;
                    crc = crc16_of(fb, 1);
                    e.bus_action = h2sps_pkg::ACT_WRITE;
                    e.tx_frame   = {fb[0], crc, 32'h0};
                    e.tx_length  = h2sps_pkg::LEN_TEMP_CMD;
                end
                default: begin
                    e.bus_action  = h2sps_pkg::ACT_READ;
                    e.rx_length   = h2sps_pkg::LEN_TEMP_RPLY;
                    e.read_status = reply_status(t.rx_frame, t.rx_ack, 4);
                    if (e.read_status == h2sps_pkg::ST_OK) begin
                        temp_byte = t.rx_frame[31:24];
                        temp_have = 1'b1;
                    end
                end
            endcase
            seq_phase = t_seq_phase'(seq_phase + 2'd1);
        end
        // Drop stale readings once no good concentration read came in time.
        if (age_ms > cfg_timeout) begin
            h2_word   = '0;
            h2_have   = 1'b0;
            temp_byte = '0;
            temp_have = 1'b0;
            err_bit   = 1'b1;
        end
        e.h2_value      = h2_word;
        e.h2_valid      = h2_have;
        e.temperature_c = temp_byte;
        e.temp_valid    = temp_have;
        e.error_flag    = err_bit;
        due_beats.push_back(e);
    endtask

    // Build a reply for the read kind that the given phase issues.
    function automatic logic [39:0] build_reply(input t_seq_phase ph, input t_reply_kind kind);
        logic [7:0]  rb [7];
        logic [15:0] crc;
        int          n, i;
        for (i = 0; i < 7; i++) rb[i] = 8'($urandom);
        if (kind == RPLY_NOISE) return {8'($urandom), 32'($urandom)};
        n = (ph == PH_TEMP_READ) ? 4 : 5;
        rb[0] = (kind == RPLY_STATUS) ? 8'($urandom_range(1, 255)) : 8'h00;
        crc = crc16_of(rb, n - 2);
        if (kind == RPLY_BADCRC) crc = crc ^ 16'($urandom_range(1, 65535));
        rb[n - 2] = crc[15:8];
        rb[n - 1] = crc[7:0];
        return {rb[0], rb[1], rb[2], rb[3], rb[4]};
    endfunction

    // Mostly well-formed replies, the rest failed reads of every flavor.
    function automatic t_tick_beat random_tick();
        t_tick_beat  t;
        t_reply_kind kind;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 70) kind = RPLY_GOOD;
        else if (roll < 78) kind = RPLY_NOACK;
        else if (roll < 86) kind = RPLY_BADCRC;
        else if (roll < 94) kind = RPLY_STATUS;
        else kind = RPLY_NOISE;
        t.humidity_q4     = 11'($urandom_range(2047));
        t.ambient_temp_q4 = 13'($urandom);
        t.pressure_mbar   = 12'($urandom_range(4095));
        t.rx_frame        = build_reply(seq_phase, kind);
        if (kind == RPLY_NOISE) t.rx_ack = 1'($urandom);
        else t.rx_ack = (kind != RPLY_NOACK);
        return t;
    endfunction

    // Present one tick beat, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_tick(input t_tick_beat t);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.humidity_q4     <= t.humidity_q4;
        tick_ch.ambient_temp_q4 <= t.ambient_temp_q4;
        tick_ch.pressure_mbar   <= t.pressure_mbar;
        tick_ch.rx_frame        <= t.rx_frame;
        tick_ch.rx_ack          <= t.rx_ack;
        do @(posedge clk); while (!tick_ch.ready);
        advance_sequencer(t);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (due_beats.size() != 0);
    endtask

    // Drain, then give the two pipeline stages time to empty before a register write.
    task automatic settle();
        wait_drained();
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, then access; the register takes the value when pready is seen high.
    task automatic reg_write(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == h2sps_pkg::REG_PERIOD) cfg_period = value;
        else cfg_timeout = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Compare one accepted result beat with the oldest expectation.
    task automatic check_poll_beat();
        t_poll_beat want;
        if (due_beats.size() == 0) begin
            report_mismatch("result with nothing expected", {8'h0, res_ch.tx_frame}, 64'h0);
            return;
        end
        want = due_beats.pop_front();
        if (res_ch.bus_action !== want.bus_action)
            report_mismatch("bus_action", res_ch.bus_action, want.bus_action);
        if (res_ch.tx_frame !== want.tx_frame)
            report_mismatch("tx_frame", res_ch.tx_frame, want.tx_frame);
        if (res_ch.tx_length !== want.tx_length)
            report_mismatch("tx_length", res_ch.tx_length, want.tx_length);
        if (res_ch.rx_length !== want.rx_length)
            report_mismatch("rx_length", res_ch.rx_length, want.rx_length);
        if (res_ch.read_status !== want.read_status)
            report_mismatch("read_status", res_ch.read_status, want.read_status);
        if (res_ch.h2_value !== want.h2_value)
            report_mismatch("h2_value", res_ch.h2_value, want.h2_value);
        if (res_ch.h2_valid !== want.h2_valid)
            report_mismatch("h2_valid", res_ch.h2_valid, want.h2_valid);
        if (res_ch.temperature_c !== want.temperature_c)
            report_mismatch("temperature_c", res_ch.temperature_c, want.temperature_c);
        if (res_ch.temp_valid !== want.temp_valid)
            report_mismatch("temp_valid", res_ch.temp_valid, want.temp_valid);
        if (res_ch.error_flag !== want.error_flag)
            report_mismatch("error_flag", res_ch.error_flag, want.error_flag);
    endtask

    // Result side: check each beat taken at this edge, then pick ready for the next one.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) check_poll_beat();
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Reset values of both registers: 60 ms phases, 550 ms timeout.
    task automatic test_reset_defaults();
        set_idling(0, 0);
        repeat (250) send_tick(random_tick());
        settle();
    endtask

    // One-tick phases: command byte rounding and clamps, every reply failure, and the
    // timeout that follows a failed concentration read.
    task automatic test_directed_fields();
        int          hum_pick[6]  = '{0, 2047, 1, 2, 1021, 1022};
        int          temp_pick[6] = '{-4096, 4095, -648, 1688, -8, 8};
        int          pres_pick[6] = '{0, 4095, 494, 495, 1304, 1305};
        t_tick_beat  t;
        t_reply_kind kind;
        int          n, ci, fi;
        reg_write(h2sps_pkg::REG_PERIOD, 16'd1);
        reg_write(h2sps_pkg::REG_TIMEOUT, 16'd3);
        ci = 0;
        fi = 0;
        for (n = 0; n < 24; n++) begin
            t = random_tick();
            t.humidity_q4     = 11'(hum_pick[ci]);
            t.ambient_temp_q4 = 13'(temp_pick[ci]);
            t.pressure_mbar   = 12'(pres_pick[ci]);
            if (seq_phase == PH_CONC_READ || seq_phase == PH_TEMP_READ) begin
                // Walk good, no-ack, bad CRC and bad status on each read kind.
                kind = t_reply_kind'((fi / 2) % 4);
                t.rx_frame = build_reply(seq_phase, kind);
                t.rx_ack   = (kind != RPLY_NOACK);
                fi++;
            end
            send_tick(t);
            if (seq_phase == PH_CONC_READ) ci = (ci + 1) % 6;
        end
        settle();
    endtask

    // Zero period acts every tick; zero timeout invalidates on every tick but a good concentration read.
    task automatic test_zero_period();
        reg_write(h2sps_pkg::REG_PERIOD, 16'd0);
        reg_write(h2sps_pkg::REG_TIMEOUT, 16'd0);
        set_idling(19, 19);
        repeat (20) send_tick(random_tick());
        settle();
    endtask

    // Random settings under each idling mix, with one full drain halfway through.
    task automatic test_random_phases();
        int send_tab[4]  = '{0, 51, 0, 19};
        int stall_tab[4] = '{0, 0, 51, 19};
        int p, n, per;
        for (p = 0; p < 4; p++) begin
            per = $urandom_range(1, 5);
            reg_write(h2sps_pkg::REG_PERIOD, 16'(per));
            reg_write(h2sps_pkg::REG_TIMEOUT, 16'($urandom_range(4 * per - 1, 12 * per)));
            set_idling(send_tab[p], stall_tab[p]);
            for (n = 0; n < 150; n++) begin
                if (n == 75) wait_drained();
                send_tick(random_tick());
            end
            settle();
        end
    endtask

    // Largest period and timeout: no phase acts and nothing times out over the run.
    // Then a short period under a near-largest timeout keeps the readings alive.
    task automatic test_large_settings();
        set_idling(0, 0);
        reg_write(h2sps_pkg::REG_PERIOD, 16'hFFFF);
        reg_write(h2sps_pkg::REG_TIMEOUT, 16'hFFFF);
        repeat (120) send_tick(random_tick());
        settle();
        reg_write(h2sps_pkg::REG_TIMEOUT, 16'hFFFE);
        reg_write(h2sps_pkg::REG_PERIOD, 16'd2);
        repeat (30) send_tick(random_tick());
        settle();
    endtask

    initial begin
        fail_count = 0;
        set_idling(0, 0);
        reset_model();
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        tick_ch.valid           <= 1'b0;
        tick_ch.humidity_q4     <= '0;
        tick_ch.ambient_temp_q4 <= '0;
        tick_ch.pressure_mbar   <= '0;
        tick_ch.rx_frame        <= '0;
        tick_ch.rx_ack          <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_fields();
        test_zero_period();
        test_random_phases();
        test_large_settings();

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/h2sps_pkg.sv
rtl/core/h2sps_if.sv
rtl/core/h2sps_cmd.sv
rtl/core/h2sps_rx_chk.sv
rtl/core/h2_sensor_poll_sequencer_unit.sv
tb/testbench.sv
